@@ rtl/kflbh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kflbh_pkg
// Shared types and constants of the keyed four-lane byte hash.
// ----------------------------------------------------------------------------
package kflbh_pkg;

  // lane multiplier and key byte multiplier
  localparam logic [30:0] LANE_MUL = 31'd1315423911;
  localparam logic [31:0] KEY_MUL  = 32'd2654435761;

  localparam int unsigned LANES     = 4;
  localparam int unsigned KEY_BYTES = 32;
  localparam int unsigned LANE_W    = $clog2(LANES);
  localparam int unsigned POS_W     = $clog2(KEY_BYTES);
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // key term is 8x32 bits, plus one bit for the data byte
  localparam int unsigned ADD_W = 41;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

  // classified item passed from front to back
  typedef struct packed {
    logic [ADD_W-1:0]  addend;
    logic [LANE_W-1:0] lane;
    logic              last;
  } item_t;

endpackage

@@ rtl/kflbh_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kflbh_byte_if / kflbh_digest_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface kflbh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kflbh_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

@@ rtl/keyed_four_lane_byte_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_four_lane_byte_hash
// Keyed hash of a byte stream into four 64-bit lane accumulators.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one message byte per item, last_byte marks the end of a
//   message. digest_out gives four items per message, lanes 0 to 3 in order,
//   last_word set on lane 3. The 32-byte key is written through the cfg
//   port as four 64-bit words (index 0 to 3) while the block is idle.
// Throughput: one byte per cycle while byte_in.ready is high. A message ends
//   with four digest words, one per cycle while digest_out.ready is high; the
//   digest buffer frees once its last word is in the output register.
// Path: the final byte passes the queue, the multiply stage and the digest
//   buffer to the output register; the lane update is a split 32-bit multiply
//   stage followed by a commit add into the lane register.
// Reset: key words, lane accumulators and byte position go to zero; the
//   queue and digest output are emptied.
// Stall: the output word is held while digest_out.ready is low; the next
//   message keeps streaming until the final byte needs the digest buffer,
//   then the queue fills and byte_in.ready drops.
// ----------------------------------------------------------------------------
module keyed_four_lane_byte_hash #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [kflbh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kflbh_pkg::WORD_W-1:0]    cfg_data,
  kflbh_byte_if.sink                      byte_in,
  kflbh_digest_if.source                  digest_out
);

  kflbh_pkg::item_t push_item;
  kflbh_pkg::item_t pop_item;
  logic             push_valid;
  logic             push_ready;
  logic             pop_valid;
  logic             pop_ready;

  // classify bytes
  kflbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_in    (byte_in),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // decoupling queue
  kflbh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // accumulate and emit
  kflbh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .digest_out (digest_out)
  );

endmodule

@@ rtl/kflbh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kflbh_front
// Key registers, byte position and key term; classifies each byte item.
// ----------------------------------------------------------------------------
module kflbh_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [kflbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kflbh_pkg::WORD_W-1:0]      cfg_data,
  kflbh_byte_if.sink                        byte_in,
  output kflbh_pkg::item_t                  push_item,
  output logic                              push_valid,
  input  logic                              push_ready
);

  logic [kflbh_pkg::WORD_W-1:0] key_word [kflbh_pkg::KEY_WORDS];
  logic [kflbh_pkg::POS_W-1:0]  byte_pos;
  logic [7:0]                   key_byte;
  logic [39:0]                  key_term;
  logic                         accept;

  assign byte_in.ready = push_ready;
  assign push_valid    = byte_in.valid;
  assign accept        = byte_in.valid && push_ready;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kflbh_pkg::KEY_WORDS; i++) key_word[i] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kflbh_pkg::REG_KEY_WORD_0: key_word[0] <= cfg_data;
        kflbh_pkg::REG_KEY_WORD_1: key_word[1] <= cfg_data;
        kflbh_pkg::REG_KEY_WORD_2: key_word[2] <= cfg_data;
        kflbh_pkg::REG_KEY_WORD_3: key_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte position, back to zero after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
    end else if (accept) begin
      byte_pos <= byte_in.last_byte ? '0 : byte_pos + 1'b1;
    end
  end

  // key byte times key multiplier, plus the data byte
  assign key_byte = key_word[byte_pos[4:3]][{byte_pos[2:0], 3'b000} +: 8];
  assign key_term = key_byte * kflbh_pkg::KEY_MUL;

  assign push_item.addend = {1'b0, key_term} + {33'd0, byte_in.data_byte};
  assign push_item.lane   = byte_pos[kflbh_pkg::LANE_W-1:0];
  assign push_item.last   = byte_in.last_byte;

endmodule

@@ rtl/kflbh_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kflbh_queue
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module kflbh_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  kflbh_pkg::item_t push_item,
  input  logic             push_valid,
  output logic             push_ready,
  output kflbh_pkg::item_t pop_item,
  output logic             pop_valid,
  input  logic             pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  kflbh_pkg::item_t  slot [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      priority if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/kflbh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kflbh_back
// Lane accumulators: split multiply stage, commit add, digest emission.
// ----------------------------------------------------------------------------
module kflbh_back (
  input  logic              clk,
  input  logic              rst,
  input  kflbh_pkg::item_t  pop_item,
  input  logic              pop_valid,
  output logic              pop_ready,
  kflbh_digest_if.source    digest_out
);

  localparam int unsigned L = kflbh_pkg::LANES;
  localparam logic [kflbh_pkg::LANE_W-1:0] LAST_LANE = kflbh_pkg::LANE_W'(L - 1);

  logic [63:0]                  acc [L];
  logic [63:0]                  dig [L];
  logic                         dig_busy;
  logic [kflbh_pkg::LANE_W-1:0] dig_idx;

  // multiply stage registers
  logic                         mul_valid;
  logic [62:0]                  mul_lo;
  logic [31:0]                  mul_hi;
  logic [kflbh_pkg::ADD_W-1:0]  mul_add;
  logic [kflbh_pkg::LANE_W-1:0] mul_lane;
  logic                         mul_last;

  logic [63:0] acc_rd;
  logic [62:0] prod_lo;
  logic [62:0] prod_hi;
  logic [63:0] acc_new;
  logic        commit;
  logic        load;
  logic        out_load;

  // a final byte waits until the previous digest has gone out
  assign commit    = mul_valid && !(mul_last && dig_busy);
  assign load      = pop_valid && (!mul_valid || commit);
  assign pop_ready = !mul_valid || commit;

  // a final byte in flight means the next item starts a fresh message
  assign acc_rd  = (mul_valid && mul_last) ? '0 : acc[pop_item.lane];
  assign prod_lo = acc_rd[31:0]  * kflbh_pkg::LANE_MUL;
  assign prod_hi = acc_rd[63:32] * kflbh_pkg::LANE_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (pop_ready) begin
      mul_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mul_lo   <= prod_lo;
      mul_hi   <= prod_hi[31:0];
      mul_add  <= pop_item.addend;
      mul_lane <= pop_item.lane;
      mul_last <= pop_item.last;
    end
  end

  // commit add, modulo 2^64
  assign acc_new = {1'b0, mul_lo} + {mul_hi, 32'd0} + {23'd0, mul_add};

  // lane accumulators and digest capture
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) acc[i] <= '0;
    end else if (commit) begin
      if (mul_last) begin
        for (int i = 0; i < L; i++) acc[i] <= '0;
      end else begin
        acc[mul_lane] <= acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && mul_last) begin
      for (int i = 0; i < L; i++) begin
        dig[i] <= (mul_lane == kflbh_pkg::LANE_W'(i)) ? acc_new : acc[i];
      end
    end
  end

  // output register, one digest word per cycle while digest_out.ready is high
  assign out_load = dig_busy && (!digest_out.valid || digest_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_busy         <= 1'b0;
      dig_idx          <= '0;
      digest_out.valid <= 1'b0;
    end else begin
      if (commit && mul_last) begin
        dig_busy <= 1'b1;
        dig_idx  <= '0;
      end else if (out_load) begin
        dig_idx <= dig_idx + 1'b1;
        if (dig_idx == LAST_LANE) dig_busy <= 1'b0;
      end
      if (out_load) begin
        digest_out.valid <= 1'b1;
      end else if (digest_out.ready) begin
        digest_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_out.digest_word <= dig[dig_idx];
      digest_out.word_index  <= dig_idx;
      digest_out.last_word   <= (dig_idx == LAST_LANE);
    end
  end

endmodule

@@ tb/sv/kflbh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kflbh_checker
// Watches the byte and digest channels and the key port of the keyed
// four-lane byte hash. Keeps its own copy of key, lane sums and byte
// position, predicts the four digest words of each message and compares
// every accepted digest word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kflbh_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [kflbh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kflbh_pkg::WORD_W-1:0]    cfg_data,
  kflbh_byte_if                           byte_ch,
  kflbh_digest_if                         digest_ch,
  output int unsigned                     mismatches,
  output int unsigned                     words_outstanding,
  output int unsigned                     words_seen
);

  localparam logic [63:0] LANE_FACTOR = 64'd1315423911;
  localparam logic [63:0] KEY_FACTOR  = 64'd2654435761;
  localparam int unsigned MAX_REPORTS = 20;

  typedef struct packed {
    logic [kflbh_pkg::WORD_W-1:0] word;
    logic [kflbh_pkg::LANE_W-1:0] lane;
    logic                         fin;
  } digest_t;

  logic [kflbh_pkg::WORD_W-1:0] key_words [kflbh_pkg::KEY_WORDS];
  logic [kflbh_pkg::WORD_W-1:0] lane_sums [kflbh_pkg::LANES];
  logic [kflbh_pkg::POS_W-1:0]  next_pos;
  digest_t                      expected_digests [$];
  int unsigned                  error_total;
  int unsigned                  word_total;

  assign mismatches = error_total;
  assign words_seen = word_total;

  // one lane step: multiply, add byte, add weighted key byte, mod 2^64
  function automatic logic [63:0] lane_update(input logic [63:0] sum, input logic [7:0] b,
                                              input logic [7:0] kb);
    return sum * LANE_FACTOR + {56'd0, b} + {56'd0, kb} * KEY_FACTOR;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_total++;
    if (error_total <= MAX_REPORTS)
      $display("[%0t] digest mismatch, %s: got 0x%h, expected 0x%h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : predict_and_compare
    digest_t                      want;
    logic [kflbh_pkg::LANE_W-1:0] lane;
    logic [7:0]                   kb;
    logic [63:0]                  sum;
    int                           i;
    if (rst) begin
      for (i = 0; i < kflbh_pkg::KEY_WORDS; i++) key_words[i] = '0;
      for (i = 0; i < kflbh_pkg::LANES; i++) lane_sums[i] = '0;
      next_pos = '0;
      expected_digests.delete();
      error_total = 0;
      word_total  = 0;
    end else begin
      // key register writes
      if (cfg_wr_en)
        key_words[cfg_index] = cfg_data;

      // accepted message byte
      if (byte_ch.valid && byte_ch.ready) begin
        lane = next_pos[kflbh_pkg::LANE_W-1:0];
        kb   = key_words[next_pos[4:3]][{next_pos[2:0], 3'b000} +: 8];
        sum  = lane_update(lane_sums[lane], byte_ch.data_byte, kb);
        lane_sums[lane] = sum;
        next_pos = next_pos + 1'b1;
        if (byte_ch.last_byte) begin
          for (i = 0; i < kflbh_pkg::LANES; i++) begin
            want.word = lane_sums[i];
            want.lane = kflbh_pkg::LANE_W'(i);
            want.fin  = (i == kflbh_pkg::LANES - 1);
            expected_digests.push_back(want);
            lane_sums[i] = '0;
          end
          next_pos = '0;
        end
      end

      // accepted digest word
      if (digest_ch.valid && digest_ch.ready) begin
        word_total++;
        if (expected_digests.size() == 0) begin
          report_mismatch("word with nothing pending", digest_ch.digest_word, '0);
        end else begin
          want = expected_digests.pop_front();
          if (digest_ch.digest_word !== want.word)
            report_mismatch($sformatf("lane %0d digest_word", want.lane),
                            digest_ch.digest_word, want.word);
          if (digest_ch.word_index !== want.lane)
            report_mismatch("word_index", 64'(digest_ch.word_index), 64'(want.lane));
          if (digest_ch.last_word !== want.fin)
            report_mismatch("last_word", 64'(digest_ch.last_word), 64'(want.fin));
        end
      end
    end
    words_outstanding <= expected_digests.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the keyed four-lane byte hash.
// Directed messages at key extremes, then random messages of mostly short
// and a few wrapping lengths under several keys, with random gaps on both
// channels, a gap-free stretch and one long receiver hold that stalls the
// byte input. Checking is done by kflbh_checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LONG_HOLD      = 120;
  localparam int unsigned IDLE_PAUSE     = 8;
  localparam int unsigned END_PAUSE      = 16;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_BYTES    = 30;

  logic                            clk;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [kflbh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kflbh_pkg::WORD_W-1:0]    cfg_data;

  bit                    steady;
  bit                    hold_request;
  int unsigned           bytes_sent;
  int unsigned           messages_sent;
  int unsigned           key_loads;
  int unsigned           long_holds;
  int unsigned           mismatches;
  int unsigned           words_outstanding;
  int unsigned           words_seen;
  int unsigned           stall_cycles;

  kflbh_byte_if   byte_ch ();
  kflbh_digest_if digest_ch ();

  keyed_four_lane_byte_hash dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_in    (byte_ch),
    .digest_out (digest_ch)
  );

  kflbh_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .byte_ch           (byte_ch),
    .digest_ch         (digest_ch),
    .mismatches        (mismatches),
    .words_outstanding (words_outstanding),
    .words_seen        (words_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly short, a few long
  function automatic int unsigned idle_len(input bit allow_zero);
    int unsigned r;
    r = $urandom_range(99);
    if (allow_zero && r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(25, 6);
  endfunction

  // message length: mostly short, some past the 32-byte key wrap
  function automatic int unsigned message_len();
    if ($urandom_range(99) < 10) return $urandom_range(40, 33);
    return $urandom_range(12, 1);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = steady ? 0 : idle_len(1'b1);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    if (fin) messages_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // stop offering, let every digest drain, then let the pipeline settle
  task automatic wait_idle(input int unsigned settle);
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic put_reg(input logic [kflbh_pkg::CFG_IDX_W-1:0] idx,
                         input logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] w0, input logic [63:0] w1,
                          input logic [63:0] w2, input logic [63:0] w3);
    put_reg(kflbh_pkg::REG_KEY_WORD_0, w0);
    put_reg(kflbh_pkg::REG_KEY_WORD_1, w1);
    put_reg(kflbh_pkg::REG_KEY_WORD_2, w2);
    put_reg(kflbh_pkg::REG_KEY_WORD_3, w3);
    cfg_wr_en <= 1'b0;
    key_loads++;
  endtask

  // receiver: random ready bursts and gaps, one long hold on request
  initial begin : digest_sink
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        digest_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        long_holds++;
      end else if (steady || $urandom_range(99) < 60) begin
        digest_ch.ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end else begin
        digest_ch.ready <= 1'b0;
        repeat (idle_len(1'b0)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_ch.valid && byte_ch.ready) || (digest_ch.valid && digest_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("no item moved for %0d cycles, %0d digest words still due",
             WATCHDOG_LIMIT, words_outstanding);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned target;
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= kflbh_pkg::REG_KEY_WORD_0;
    cfg_data          <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    digest_ch.ready   <= 1'b0;
    steady        = 1'b0;
    hold_request  = 1'b0;
    bytes_sent    = 0;
    messages_sent = 0;
    key_loads     = 0;
    long_holds    = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // one-byte messages at the byte extremes under the all-zero reset key
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_idle(IDLE_PAUSE);

    // all-ones key, five bytes so lane 0 is hit twice
    load_key('1, '1, '1, '1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle(IDLE_PAUSE);

    // key byte n equals n, so any byte-order slip shows up
    load_key(64'h0706050403020100, 64'h0F0E0D0C0B0A0908,
             64'h1716151413121110, 64'h1F1E1D1C1B1A1918);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_message(3);
    send_message(4);
    wait_idle(IDLE_PAUSE);

    // random messages under four key settings
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_key(rand_word(), rand_word(), rand_word(), rand_word());
        1: load_key(64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00,
                    64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
        2: load_key(rand_word(), rand_word(), rand_word(), rand_word());
        default: load_key('0, '1, rand_word(), rand_word());
      endcase
      // back-to-back bytes while the receiver holds off
      steady = (ph == 1);
      if (ph == 1) hold_request = 1'b1;
      if (ph == 0) send_message(37);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target)
        send_message(message_len());
      steady = 1'b0;
      wait_idle(IDLE_PAUSE);
    end

    wait_idle(END_PAUSE);
    $display("sent %0d bytes in %0d messages under %0d key loads, incl. wraps past 32 bytes",
             bytes_sent, messages_sent, key_loads);
    $display("checked %0d digest words; %0d long receiver hold(s) of %0d cycles",
             words_seen, long_holds, LONG_HOLD);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kflbh_pkg.sv
rtl/kflbh_if.sv
rtl/kflbh_front.sv
rtl/kflbh_queue.sv
rtl/kflbh_back.sv
rtl/keyed_four_lane_byte_hash.sv
tb/sv/kflbh_checker.sv
tb/sv/tb.sv
